// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/deq_pkg.sv -----
package deq_pkg;

  // Request codes
  localparam logic [1:0] OP_PUSH_HEAD = 2'd0;
  localparam logic [1:0] OP_PUSH_TAIL = 2'd1;
  localparam logic [1:0] OP_POP_HEAD  = 2'd2;
  localparam logic [1:0] OP_POP_TAIL  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int WORD_W  = 32;
  localparam int TOTAL_W = 9;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [WORD_W-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] data_out;
    logic [TOTAL_W-1:0]       item_total;
    logic                     is_empty;
  } rsp_t;

  // Per-cycle command broadcast along one row of cells
  typedef struct packed {
    logic shift_r;  // every cell takes its left neighbor, cell 0 takes the new word
    logic shift_l;  // every cell takes its right neighbor
    logic wr;       // the cell whose index matches wr_idx takes the new word
  } cell_ctl_t;

endpackage

// ----- rtl/deq_cell.sv -----
module deq_cell #(
  parameter int IDX = 0,
  parameter int CW  = 9
) (
  input  logic                          clk,
  input  deq_pkg::cell_ctl_t            ctl,
  input  logic [deq_pkg::WORD_W-1:0]    left_word,
  input  logic [deq_pkg::WORD_W-1:0]    right_word,
  input  logic [CW-1:0]                 wr_idx,
  input  logic [deq_pkg::WORD_W-1:0]    wr_word,
  output logic [deq_pkg::WORD_W-1:0]    word
);

  // Shift toward either neighbor, or take the broadcast word when addressed
  always_ff @(posedge clk) begin
    if (ctl.shift_r) begin
      word <= left_word;
    end else if (ctl.shift_l) begin
      word <= right_word;
    end else if (ctl.wr && (wr_idx == CW'(IDX))) begin
      word <= wr_word;
    end
  end

endmodule

// ----- rtl/deq_chain.sv -----
module deq_chain #(
  parameter int DEPTH = 256,
  parameter int CW    = 9
) (
  input  logic                       clk,
  input  deq_pkg::cell_ctl_t         ctl,
  input  logic [CW-1:0]              wr_idx,
  input  logic [deq_pkg::WORD_W-1:0] wr_word,
  output logic [deq_pkg::WORD_W-1:0] head_word
);

  logic [deq_pkg::WORD_W-1:0] words [DEPTH];

  // Build the row; cell 0 takes the new word on a right shift, the last cell takes zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [deq_pkg::WORD_W-1:0] left_word;
    logic [deq_pkg::WORD_W-1:0] right_word;

    if (i == 0) begin : g_first
      assign left_word = wr_word;
    end else begin : g_inner_l
      assign left_word = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_inner_r
      assign right_word = words[i+1];
    end

    deq_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .left_word  (left_word),
      .right_word (right_word),
      .wr_idx     (wr_idx),
      .wr_word    (wr_word),
      .word       (words[i])
    );
  end

  assign head_word = words[0];

endmodule

// ----- rtl/double_ended_queue_unit.sv -----
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_ready | deq_pkg::req_t (op, data_in)
// rsp     | out       | rsp_valid / rsp_ready | deq_pkg::rsp_t (status, data_out,
//         |           |                       |   item_total, is_empty)
//
// One request per clock while results are taken; its result is registered and shows in the cycle after the beat.
// Two rows of DEPTH cells hold the words, one ordered from the head and one from the
// tail, so either end is always at cell 0.
// Reset clears the word count and the result valid; cells are read only once written.
// A stalled result holds req_ready low until rsp_ready takes it.
module double_ended_queue_unit #(
  parameter int DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  deq_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output deq_pkg::rsp_t  rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]              count;
  logic [CW-1:0]              count_next;
  logic                       req_beat;
  logic                       is_push;
  logic                       full;
  logic                       empty;
  logic                       ok;
  logic                       full_push;
  deq_pkg::cell_ctl_t         ctl_head;
  deq_pkg::cell_ctl_t         ctl_tail;
  logic [deq_pkg::WORD_W-1:0] head_word;
  logic [deq_pkg::WORD_W-1:0] tail_word;
  deq_pkg::rsp_t              rsp_next;

  assign req_ready = !rsp_valid || rsp_ready;
  assign req_beat  = req_valid && req_ready;
  assign is_push   = (req.op == deq_pkg::OP_PUSH_HEAD) || (req.op == deq_pkg::OP_PUSH_TAIL);
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign ok        = is_push ? !full : !empty;
  assign full_push = req_beat && is_push && full;

  // Decode the request into commands for both rows and the new count
  always_comb begin
    ctl_head   = '0;
    ctl_tail   = '0;
    count_next = count;
    if (req_beat && ok) begin
      case (req.op)
        deq_pkg::OP_PUSH_HEAD: begin
          ctl_head.shift_r = 1'b1;
          ctl_tail.wr      = 1'b1;
          count_next       = count + CW'(1);
        end
        deq_pkg::OP_PUSH_TAIL: begin
          ctl_head.wr      = 1'b1;
          ctl_tail.shift_r = 1'b1;
          count_next       = count + CW'(1);
        end
        deq_pkg::OP_POP_HEAD: begin
          ctl_head.shift_l = 1'b1;
          count_next       = count - CW'(1);
        end
        deq_pkg::OP_POP_TAIL: begin
          ctl_tail.shift_l = 1'b1;
          count_next       = count - CW'(1);
        end
        default: begin
          count_next = count;
        end
      endcase
    end
  end

  // Form the result from the current ends before the rows move
  always_comb begin
    rsp_next.status   = deq_pkg::ST_OK;
    rsp_next.data_out = '0;
    if (!ok) begin
      rsp_next.status = is_push ? deq_pkg::ST_FULL : deq_pkg::ST_EMPTY;
    end else if (req.op == deq_pkg::OP_POP_HEAD) begin
      rsp_next.data_out = head_word;
    end else if (req.op == deq_pkg::OP_POP_TAIL) begin
      rsp_next.data_out = tail_word;
    end
    rsp_next.item_total = deq_pkg::TOTAL_W'(count_next);
    rsp_next.is_empty   = (count_next == '0);
  end

  // Row ordered from the head: cell 0 is the head word
  deq_chain #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_head_chain (
    .clk       (clk),
    .ctl       (ctl_head),
    .wr_idx    (count),
    .wr_word   (req.data_in),
    .head_word (head_word)
  );

  // Row ordered from the tail: cell 0 is the tail word
  deq_chain #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_tail_chain (
    .clk       (clk),
    .ctl       (ctl_tail),
    .wr_idx    (count),
    .wr_word   (req.data_in),
    .head_word (tail_word)
  );

  // Advance the count and hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (req_beat) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_beat) begin
      rsp <= rsp_next;
    end
  end

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_count_bound, count <= CW'(DEPTH), "word count exceeds depth")
  `ASSERT_NEXT(a_full_report, full_push, rsp.status == deq_pkg::ST_FULL, "full push missed")
  `ASSERT_ALWAYS(a_rows_agree, (count == CW'(1)) |-> (head_word == tail_word), "rows disagree")

endmodule

// ----- tb/double_ended_queue_unit_tb.sv -----
`timescale 1ns / 100ps

module double_ended_queue_unit_tb;

  localparam int DEPTH       = 256;
  localparam int IDLE_PCT    = 31;
  localparam int HOLD_CYCLES = 300;
  localparam int PRINT_CAP   = 40;

  // One row of the directed table; want is used only when typed is set
  typedef struct {
    deq_pkg::req_t req;
    bit            typed;
    deq_pkg::rsp_t want;
  } deq_row_t;

  typedef struct {
    bit            typed;
    deq_pkg::rsp_t want;
  } preset_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_ready;
  deq_pkg::req_t  req = '0;
  logic           rsp_valid;
  logic           rsp_ready = 1'b0;
  deq_pkg::rsp_t  rsp;

  // Shadow copy of the queue contents
  logic signed [deq_pkg::WORD_W-1:0] ring_words [DEPTH];
  int head_slot = 0;
  int word_count = 0;

  deq_pkg::rsp_t expected_rsp_q [$];
  preset_t       preset_rsp_q [$];
  deq_row_t      directed_rows [$];

  int  fail_count = 0;
  int  reqs_sent = 0;
  int  results_checked = 0;
  int  pushes_ok = 0;
  int  pops_ok = 0;
  int  empty_refusals = 0;
  int  full_refusals = 0;
  int  peak_count = 0;
  int  holds_asked = 0;
  bit  rx_steady = 1'b0;
  bit  tx_steady = 1'b0;

  double_ended_queue_unit #(.DEPTH(DEPTH)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one request to the shadow queue and return the result it should give
  function automatic deq_pkg::rsp_t deq_apply(input deq_pkg::req_t r);
    deq_pkg::rsp_t res;
    res = '0;
    res.status = deq_pkg::ST_OK;
    case (r.op)
      deq_pkg::OP_PUSH_HEAD, deq_pkg::OP_PUSH_TAIL: begin
        if (word_count >= DEPTH) begin
          res.status = deq_pkg::ST_FULL;
        end else if (r.op == deq_pkg::OP_PUSH_HEAD) begin
          head_slot = (head_slot + DEPTH - 1) % DEPTH;
          ring_words[head_slot] = r.data_in;
          word_count++;
        end else begin
          ring_words[(head_slot + word_count) % DEPTH] = r.data_in;
          word_count++;
        end
      end
      default: begin
        if (word_count == 0) begin
          res.status = deq_pkg::ST_EMPTY;
        end else if (r.op == deq_pkg::OP_POP_HEAD) begin
          res.data_out = ring_words[head_slot];
          head_slot = (head_slot + 1) % DEPTH;
          word_count--;
        end else begin
          res.data_out = ring_words[(head_slot + word_count - 1) % DEPTH];
          word_count--;
        end
      end
    endcase
    res.item_total = word_count[deq_pkg::TOTAL_W-1:0];
    res.is_empty = (word_count == 0);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < PRINT_CAP)
      $display("MISMATCH result %0d %s: got %h, expected %h", results_checked, what, got, want);
    fail_count++;
  endtask

  // Check result beats against the oldest expectation, then predict accepted requests
  always @(posedge clk) begin : monitor
    deq_pkg::rsp_t want;
    preset_t       preset;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("with nothing expected, status", 32'(rsp.status), '0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", 32'(rsp.status), 32'(want.status));
          if (rsp.data_out !== want.data_out)
            report_mismatch("data_out", rsp.data_out, want.data_out);
          if (rsp.item_total !== want.item_total)
            report_mismatch("item_total", 32'(rsp.item_total), 32'(want.item_total));
          if (rsp.is_empty !== want.is_empty)
            report_mismatch("is_empty", 32'(rsp.is_empty), 32'(want.is_empty));
        end
        results_checked++;
      end
      if (req_valid && req_ready) begin
        want = deq_apply(req);
        case (want.status)
          deq_pkg::ST_EMPTY: empty_refusals++;
          deq_pkg::ST_FULL:  full_refusals++;
          default: begin
            if (req.op == deq_pkg::OP_PUSH_HEAD || req.op == deq_pkg::OP_PUSH_TAIL) pushes_ok++;
            else pops_ok++;
          end
        endcase
        if (word_count > peak_count) peak_count = word_count;
        preset = preset_rsp_q.pop_front();
        expected_rsp_q.push_back(preset.typed ? preset.want : want);
      end
    end
  end

  // Result side: random stalls, steady stretches and long hold-offs on request
  initial begin : rsp_sink
    int hold_left;
    int holds_seen;
    hold_left = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk);
      if (holds_asked != holds_seen) begin
        holds_seen = holds_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (rx_steady) begin
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic add_row(input logic [1:0] op, input logic [31:0] word, input bit typed,
                         input logic [1:0] status, input logic [31:0] popped,
                         input int total, input bit empty);
    deq_row_t row;
    row.req.op = op;
    row.req.data_in = word;
    row.typed = typed;
    row.want.status = status;
    row.want.data_out = popped;
    row.want.item_total = total[deq_pkg::TOTAL_W-1:0];
    row.want.is_empty = empty;
    directed_rows.push_back(row);
  endtask

  // Offer one request beat, with random idle cycles first; return once accepted
  task automatic offer_req(input deq_pkg::req_t r, input bit typed, input deq_pkg::rsp_t want);
    preset_t preset;
    while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    preset.typed = typed;
    preset.want = want;
    preset_rsp_q.push_back(preset);
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    reqs_sent++;
  endtask

  // Hold off the request side until every expected result has come back
  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (results_checked < reqs_sent);
  endtask

  // Random requests; push_pct steers the queue toward full or empty
  task automatic run_phase(input int n_items, input int push_pct);
    deq_pkg::req_t r;
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(99) < push_pct)
        r.op = $urandom_range(1) ? deq_pkg::OP_PUSH_TAIL : deq_pkg::OP_PUSH_HEAD;
      else
        r.op = $urandom_range(1) ? deq_pkg::OP_POP_TAIL : deq_pkg::OP_POP_HEAD;
      case ($urandom_range(15))
        0:       r.data_in = 32'h7FFF_FFFF;
        1:       r.data_in = 32'h8000_0000;
        2:       r.data_in = '1;
        3:       r.data_in = '0;
        default: r.data_in = $urandom();
      endcase
      offer_req(r, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Pops right after reset, then extreme words in from both ends and out again
    add_row(deq_pkg::OP_POP_HEAD,  32'h1234_5678, 1, deq_pkg::ST_EMPTY, 32'h0,         0, 1);
    add_row(deq_pkg::OP_POP_TAIL,  32'hFFFF_FFFF, 1, deq_pkg::ST_EMPTY, 32'h0,         0, 1);
    add_row(deq_pkg::OP_PUSH_HEAD, 32'h7FFF_FFFF, 1, deq_pkg::ST_OK,    32'h0,         1, 0);
    add_row(deq_pkg::OP_PUSH_TAIL, 32'h8000_0000, 1, deq_pkg::ST_OK,    32'h0,         2, 0);
    add_row(deq_pkg::OP_PUSH_HEAD, 32'hFFFF_FFFF, 1, deq_pkg::ST_OK,    32'h0,         3, 0);
    add_row(deq_pkg::OP_PUSH_TAIL, 32'h0000_0000, 1, deq_pkg::ST_OK,    32'h0,         4, 0);
    add_row(deq_pkg::OP_POP_HEAD,  32'h0,         1, deq_pkg::ST_OK,    32'hFFFF_FFFF, 3, 0);
    add_row(deq_pkg::OP_POP_TAIL,  32'h0,         1, deq_pkg::ST_OK,    32'h0000_0000, 2, 0);
    add_row(deq_pkg::OP_POP_TAIL,  32'h0,         1, deq_pkg::ST_OK,    32'h8000_0000, 1, 0);
    add_row(deq_pkg::OP_POP_HEAD,  32'h0,         1, deq_pkg::ST_OK,    32'h7FFF_FFFF, 0, 1);
    add_row(deq_pkg::OP_POP_HEAD,  32'hDEAD_BEEF, 1, deq_pkg::ST_EMPTY, 32'h0,         0, 1);
    // Alternating bit patterns, tail pops reaching the word pushed at the head
    add_row(deq_pkg::OP_PUSH_TAIL, 32'h5555_5555, 1, deq_pkg::ST_OK,    32'h0,         1, 0);
    add_row(deq_pkg::OP_PUSH_HEAD, 32'hAAAA_AAAA, 1, deq_pkg::ST_OK,    32'h0,         2, 0);
    add_row(deq_pkg::OP_POP_TAIL,  32'h0,         1, deq_pkg::ST_OK,    32'h5555_5555, 1, 0);
    add_row(deq_pkg::OP_POP_TAIL,  32'h0,         1, deq_pkg::ST_OK,    32'hAAAA_AAAA, 0, 1);
    add_row(deq_pkg::OP_POP_TAIL,  32'h0,         1, deq_pkg::ST_EMPTY, 32'h0,         0, 1);
    // Mixed traffic left to the shadow queue
    add_row(deq_pkg::OP_PUSH_HEAD, 32'h0000_0001, 0, deq_pkg::ST_OK, 32'h0, 0, 0);
    add_row(deq_pkg::OP_PUSH_HEAD, 32'hFFFF_FFFE, 0, deq_pkg::ST_OK, 32'h0, 0, 0);
    add_row(deq_pkg::OP_PUSH_TAIL, 32'h0F0F_0F0F, 0, deq_pkg::ST_OK, 32'h0, 0, 0);
    add_row(deq_pkg::OP_POP_HEAD,  32'h0,         0, deq_pkg::ST_OK, 32'h0, 0, 0);
    add_row(deq_pkg::OP_PUSH_TAIL, 32'hF0F0_F0F0, 0, deq_pkg::ST_OK, 32'h0, 0, 0);
    add_row(deq_pkg::OP_POP_TAIL,  32'h0,         0, deq_pkg::ST_OK, 32'h0, 0, 0);
    add_row(deq_pkg::OP_POP_HEAD,  32'h0,         0, deq_pkg::ST_OK, 32'h0, 0, 0);
    add_row(deq_pkg::OP_POP_HEAD,  32'h0,         0, deq_pkg::ST_OK, 32'h0, 0, 0);

    foreach (directed_rows[n])
      offer_req(directed_rows[n].req, directed_rows[n].typed, directed_rows[n].want);
    wait_drained();

    // Balanced traffic wraps the head around the ring
    run_phase(300, 50);
    // Fill to full while the result side holds off for a long stretch
    holds_asked <= holds_asked + 1;
    run_phase(380, 90);
    wait_drained();
    // Drain back to empty and keep popping
    run_phase(380, 10);
    wait_drained();
    // Back-to-back beats with no idling on either side
    tx_steady = 1'b1;
    rx_steady <= 1'b1;
    run_phase(100, 50);
    tx_steady = 1'b0;
    rx_steady <= 1'b0;
    run_phase(40, 55);

    wait_drained();
    repeat (4) @(posedge clk);
    if (expected_rsp_q.size() != 0) begin
      $display("%0d expected results never arrived", expected_rsp_q.size());
      fail_count++;
    end
    $display("Checked %0d results from %0d requests, queue peaked at %0d words.",
             results_checked, reqs_sent, peak_count);
    $display("Pushes %0d, pops %0d, refused as empty %0d, refused as full %0d.",
             pushes_ok, pops_ok, empty_refusals, full_refusals);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #400000;
    $display("Timeout: %0d requests sent, %0d results checked", reqs_sent, results_checked);
    $display("Some tests failed");
    $finish;
  end

endmodule
